[hw/rtl/tpmas_pkg.sv]
package tpmas_pkg;

    localparam int TOKEN_W  = 32;
    localparam int END_W    = 32;
    localparam int DIGEST_W = 64;
    localparam int LENGTH_W = 32;

    localparam int FIRST_TOKEN_LSB  = 0;
    localparam int SECOND_TOKEN_LSB = FIRST_TOKEN_LSB + TOKEN_W;
    localparam int FIRST_START_BIT  = SECOND_TOKEN_LSB + TOKEN_W;
    localparam int FIRST_END_LSB    = FIRST_START_BIT + 1;
    localparam int FIRST_DIG_LSB    = FIRST_END_LSB + END_W;
    localparam int SECOND_START_BIT = FIRST_DIG_LSB + DIGEST_W;
    localparam int SECOND_END_LSB   = SECOND_START_BIT + 1;
    localparam int SECOND_DIG_LSB   = SECOND_END_LSB + END_W;
    localparam int IN_USED_W        = SECOND_DIG_LSB + DIGEST_W;
    localparam int IN_DATA_W        = ((IN_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic                order_error;
        logic [LENGTH_W-1:0] length;
    } result_t;

endpackage

[hw/rtl/token_prefix_match_atomic_spans_unit.sv]
// Only a final position or an empty pair yields a result, registered into the output stage.
// Throughput: one item per cycle while the skid entry is empty (s_tready high).
// A two-entry output stage lets input items flow while one result waits to be taken.
// Reset (aresetn low at a clock edge) clears the matching state and empties the output stage.
module token_prefix_match_atomic_spans_unit #(
    parameter int CURSOR_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_token, second_token, first_span_starts, first_span_end, first_span_digest,
    // second_span_starts, second_span_end, second_span_digest, zero padding
    input  logic [tpmas_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    // empty_pair
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // shared_length
    output logic [tpmas_pkg::LENGTH_W-1:0] m_tdata,
    // span_order_error
    output logic                           m_tuser
);

    typedef logic [CURSOR_BITS-1:0] cursor_t;

    logic                            still_matching_reg, still_matching_next;
    cursor_t                         match_count_reg, match_count_next;
    cursor_t                         position_count_reg, position_count_next;
    cursor_t                         open_span_begin_reg, open_span_begin_next;
    cursor_t                         open_span_end_reg, open_span_end_next;
    cursor_t                         first_previous_end_reg, first_previous_end_next;
    cursor_t                         second_previous_end_reg, second_previous_end_next;
    logic                            order_fault_reg, order_fault_next;

    logic                            out_valid_reg, skid_valid_reg;
    tpmas_pkg::result_t              out_data_reg, skid_data_reg;

    logic [tpmas_pkg::TOKEN_W-1:0]   first_token, second_token;
    logic [tpmas_pkg::DIGEST_W-1:0]  first_digest, second_digest;
    logic                            first_starts, second_starts;
    cursor_t                         first_end, second_end;
    logic                            in_fire, out_fire, res_valid, agree;
    cursor_t                         pos_inc;
    cursor_t                         length_value;
    tpmas_pkg::result_t              res;

    assign first_token   = s_tdata[tpmas_pkg::FIRST_TOKEN_LSB +: tpmas_pkg::TOKEN_W];
    assign second_token  = s_tdata[tpmas_pkg::SECOND_TOKEN_LSB +: tpmas_pkg::TOKEN_W];
    assign first_starts  = s_tdata[tpmas_pkg::FIRST_START_BIT];
    assign second_starts = s_tdata[tpmas_pkg::SECOND_START_BIT];
    assign first_end     = s_tdata[tpmas_pkg::FIRST_END_LSB +: CURSOR_BITS];
    assign second_end    = s_tdata[tpmas_pkg::SECOND_END_LSB +: CURSOR_BITS];
    assign first_digest  = s_tdata[tpmas_pkg::FIRST_DIG_LSB +: tpmas_pkg::DIGEST_W];
    assign second_digest = s_tdata[tpmas_pkg::SECOND_DIG_LSB +: tpmas_pkg::DIGEST_W];

    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = out_valid_reg && m_tready;
    assign res_valid = in_fire && (s_tuser || s_tlast);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.length;
    assign m_tuser  = out_data_reg.order_error;

    assign pos_inc = (&position_count_reg) ? position_count_reg : position_count_reg + 1'b1;

    always_comb begin
        agree = (first_token == second_token) && (first_starts == second_starts);
        if (first_starts) begin
            agree = agree && (first_end == second_end) && (first_digest == second_digest);
        end

        still_matching_next      = still_matching_reg;
        match_count_next         = match_count_reg;
        open_span_begin_next     = open_span_begin_reg;
        open_span_end_next       = open_span_end_reg;
        first_previous_end_next  = first_previous_end_reg;
        second_previous_end_next = second_previous_end_reg;
        order_fault_next         = order_fault_reg;
        position_count_next      = pos_inc;

        if (first_starts) begin
            if (first_end <= position_count_reg || position_count_reg < first_previous_end_reg)
            begin
                order_fault_next = 1'b1;
            end
            first_previous_end_next = first_end;
        end
        if (second_starts) begin
            if (second_end <= position_count_reg || position_count_reg < second_previous_end_reg)
            begin
                order_fault_next = 1'b1;
            end
            second_previous_end_next = second_end;
        end

        if (still_matching_reg) begin
            if (agree) begin
                match_count_next = pos_inc;
                if (first_starts) begin
                    open_span_begin_next = position_count_reg;
                    open_span_end_next   = first_end;
                end
            end else begin
                still_matching_next = 1'b0;
            end
        end

        length_value = match_count_next;
        if (open_span_begin_next < length_value && length_value < open_span_end_next) begin
            length_value = open_span_begin_next;
        end

        if (s_tuser) begin
            res.length      = '0;
            res.order_error = 1'b0;
        end else begin
            res.length      = tpmas_pkg::LENGTH_W'(length_value);
            res.order_error = order_fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_matching_reg      <= 1'b1;
            match_count_reg         <= '0;
            position_count_reg      <= '0;
            open_span_begin_reg     <= '0;
            open_span_end_reg       <= '0;
            first_previous_end_reg  <= '0;
            second_previous_end_reg <= '0;
            order_fault_reg         <= 1'b0;
            out_valid_reg           <= 1'b0;
            skid_valid_reg          <= 1'b0;
        end else begin
            if (in_fire) begin
                if (s_tuser || s_tlast) begin
                    still_matching_reg      <= 1'b1;
                    match_count_reg         <= '0;
                    position_count_reg      <= '0;
                    open_span_begin_reg     <= '0;
                    open_span_end_reg       <= '0;
                    first_previous_end_reg  <= '0;
                    second_previous_end_reg <= '0;
                    order_fault_reg         <= 1'b0;
                end else begin
                    still_matching_reg      <= still_matching_next;
                    match_count_reg         <= match_count_next;
                    position_count_reg      <= position_count_next;
                    open_span_begin_reg     <= open_span_begin_next;
                    open_span_end_reg       <= open_span_end_next;
                    first_previous_end_reg  <= first_previous_end_next;
                    second_previous_end_reg <= second_previous_end_next;
                    order_fault_reg         <= order_fault_next;
                end
            end

            if (!out_valid_reg || out_fire) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else if (res_valid) begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= res;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    a_match_within_positions: assert property (@(posedge aclk) disable iff (!aresetn)
        match_count_reg <= position_count_reg)
        else $error("Match count runs ahead of the position count.");

    a_span_begin_within_match: assert property (@(posedge aclk) disable iff (!aresetn)
        open_span_begin_reg <= match_count_reg)
        else $error("Matched span begins beyond the matched length.");

    a_empty_pair_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser && (!out_valid_reg || m_tready))
        |=> (m_tvalid && m_tdata == '0 && !m_tuser))
        else $error("Empty pair did not give a zero result in the next cycle.");

    a_state_cleared_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (position_count_reg == '0 && still_matching_reg && !order_fault_reg))
        else $error("Matching state not cleared after a result.");

endmodule
